@@ sv/cda_pkg.sv @@
package cda_pkg;

  localparam int unsigned YEAR_MAX_DEF = 9999;

  localparam logic [13:0] RESET_YEAR  = 14'd1998;
  localparam logic [3:0]  RESET_MONTH = 4'd12;
  localparam logic [4:0]  RESET_DAY   = 5'd30;

  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_NEXT_DAY   = 3'd1;
  localparam logic [2:0] CMD_PREV_DAY   = 3'd2;
  localparam logic [2:0] CMD_ADD_DAYS   = 3'd3;
  localparam logic [2:0] CMD_ADD_MONTHS = 3'd4;
  localparam logic [2:0] CMD_ADD_YEARS  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LOAD = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [3:0] DEC             = 4'd12;
  localparam logic [4:0] DAYS_LONG_MONTH = 5'd31;

  // Reciprocal of 3 scaled by 2**16. The quotient is exact for dividends below 2**15.
  localparam logic [14:0] RECIP3 = 15'd21846;

  // Modular inverse of 25 modulo 2**14 and the largest quotient that fits in 14 bits.
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] MAX_Q25   = 14'd655;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD_CHECK,
    OP_FWD,
    OP_BACK,
    OP_DAY_STEP,
    OP_DIV_STEP,
    OP_MONTH_YEAR,
    OP_YEAR_ADD,
    OP_CLAMP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   start;
    logic   start_load;
    logic   start_div;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic failed;
    logic out_busy;
  } dp_stat_t;

  // A year is a leap year when it is divisible by 4, except for multiples of 100
  // that are not multiples of 400. Divisibility by 25 uses a modular inverse.
  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    prod  = 28'(y) * 28'(INV25);
    div25 = (prod[13:0] <= MAX_Q25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] d;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                      d = leap ? 5'd29 : 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/cda_ctrl.sv @@
module cda_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         command,
  input  cda_pkg::dp_stat_t  stat,
  output cda_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FWD,
    S_BACK,
    S_DAYS,
    S_DIV,
    S_MADD,
    S_YADD,
    S_CLAMP,
    S_FIN
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.start      = 1'b0;
    cmd.start_load = 1'b0;
    cmd.start_div  = 1'b0;
    cmd.op         = cda_pkg::OP_IDLE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          case (command)
            cda_pkg::CMD_LOAD: begin
              cmd.start_load = 1'b1;
              state_next     = S_LOAD;
            end
            cda_pkg::CMD_NEXT_DAY:   state_next = S_FWD;
            cda_pkg::CMD_PREV_DAY:   state_next = S_BACK;
            cda_pkg::CMD_ADD_DAYS:   state_next = S_DAYS;
            cda_pkg::CMD_ADD_MONTHS: begin
              cmd.start_div = 1'b1;
              state_next    = S_DIV;
            end
            cda_pkg::CMD_ADD_YEARS:  state_next = S_YADD;
            default:                 state_next = S_FIN;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op     = cda_pkg::OP_LOAD_CHECK;
        state_next = S_FIN;
      end
      S_FWD: begin
        cmd.op     = cda_pkg::OP_FWD;
        state_next = S_FIN;
      end
      S_BACK: begin
        cmd.op     = cda_pkg::OP_BACK;
        state_next = S_FIN;
      end
      S_DAYS: begin
        if (stat.cnt_zero || stat.failed) begin
          state_next = S_FIN;
        end else begin
          cmd.op = cda_pkg::OP_DAY_STEP;
        end
      end
      S_DIV: begin
        cmd.op     = cda_pkg::OP_DIV_STEP;
        state_next = S_MADD;
      end
      S_MADD: begin
        cmd.op     = cda_pkg::OP_MONTH_YEAR;
        state_next = S_CLAMP;
      end
      S_YADD: begin
        cmd.op     = cda_pkg::OP_YEAR_ADD;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op     = cda_pkg::OP_CLAMP;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op     = cda_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/cda_datapath.sv @@
module cda_datapath #(
  parameter int unsigned YEAR_MAX = cda_pkg::YEAR_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cda_pkg::dp_cmd_t  cmd,
  output cda_pkg::dp_stat_t stat,
  input  logic [15:0]       amount,
  input  logic [13:0]       load_year,
  input  logic [3:0]        load_month,
  input  logic [4:0]        load_day,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [13:0]       year_out,
  output logic [3:0]        month_out,
  output logic [4:0]        day_out,
  output logic [1:0]        status
);

  localparam logic [16:0] YMAX17 = 17'(YEAR_MAX);
  localparam logic [13:0] YMAX14 = 14'(YEAR_MAX);

  logic [13:0] year, wy;
  logic [3:0]  month, wm;
  logic [4:0]  day, wd;
  logic [15:0] cnt;
  logic [16:0] dq;
  logic [3:0]  rem;
  logic [1:0]  st;

  logic        leap_w;
  logic [4:0]  dim_cur, dim_prev;
  logic [13:0] fwd_y, back_y;
  logic [3:0]  fwd_m, back_m;
  logic [4:0]  fwd_d, back_d;
  logic        fwd_fail, back_fail, load_bad;
  logic [14:0] div_x, div_back;
  logic [29:0] div_prod;
  logic [13:0] div_q;
  logic [1:0]  div_r3;
  logic [16:0] ysum_months, ysum_years;

  assign leap_w   = cda_pkg::is_leap(wy);
  assign dim_cur  = cda_pkg::month_days(leap_w, wm);
  assign dim_prev = cda_pkg::month_days(leap_w, wm - 4'd1);

  always_comb begin
    fwd_y    = wy;
    fwd_m    = wm;
    fwd_d    = wd;
    fwd_fail = 1'b0;
    if (wd < dim_cur) begin
      fwd_d = wd + 5'd1;
    end else if (wm < cda_pkg::MONTHS_PER_YEAR) begin
      fwd_m = wm + 4'd1;
      fwd_d = 5'd1;
    end else if (wy >= YMAX14) begin
      fwd_fail = 1'b1;
    end else begin
      fwd_y = wy + 14'd1;
      fwd_m = 4'd1;
      fwd_d = 5'd1;
    end
  end

  always_comb begin
    back_y    = wy;
    back_m    = wm;
    back_d    = wd;
    back_fail = 1'b0;
    if (wd > 5'd1) begin
      back_d = wd - 5'd1;
    end else if (wm > 4'd1) begin
      back_m = wm - 4'd1;
      back_d = dim_prev;
    end else if (wy == 14'd0) begin
      back_fail = 1'b1;
    end else begin
      back_y = wy - 14'd1;
      back_m = cda_pkg::DEC;
      back_d = cda_pkg::DAYS_LONG_MONTH;
    end
  end

  assign load_bad = (wy > YMAX14) || (wd == 5'd0) || (wd > dim_cur);

  // The month total is divided by 4 with a shift and then by 3 with a reciprocal.
  assign div_x       = dq[16:2];
  assign div_prod    = 30'(div_x) * 30'(cda_pkg::RECIP3);
  assign div_q       = div_prod[29:16];
  assign div_back    = {1'b0, div_q} + {div_q, 1'b0};
  assign div_r3      = 2'(div_x - div_back);
  assign ysum_months = 17'(wy) + dq;
  assign ysum_years  = 17'(wy) + 17'(cnt);

  assign stat.cnt_zero = (cnt == 16'd0);
  assign stat.failed   = (st != cda_pkg::ST_OK);
  assign stat.out_busy = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      st  <= cda_pkg::ST_OK;
      cnt <= amount;
      if (cmd.start_load) begin
        wy <= load_year;
        wm <= load_month;
        wd <= load_day;
      end else begin
        wy <= year;
        wm <= month;
        wd <= day;
      end
      if (cmd.start_div) begin
        dq  <= 17'(month - 4'd1) + 17'(amount);
        rem <= 4'd0;
      end
    end else begin
      case (cmd.op)
        cda_pkg::OP_LOAD_CHECK: begin
          if (load_bad) begin
            st <= cda_pkg::ST_BAD_LOAD;
          end
        end
        cda_pkg::OP_FWD, cda_pkg::OP_DAY_STEP: begin
          cnt <= cnt - 16'd1;
          if (fwd_fail) begin
            st <= cda_pkg::ST_RANGE;
          end else begin
            wy <= fwd_y;
            wm <= fwd_m;
            wd <= fwd_d;
          end
        end
        cda_pkg::OP_BACK: begin
          if (back_fail) begin
            st <= cda_pkg::ST_RANGE;
          end else begin
            wy <= back_y;
            wm <= back_m;
            wd <= back_d;
          end
        end
        cda_pkg::OP_DIV_STEP: begin
          rem <= {div_r3, dq[1:0]};
          dq  <= {3'd0, div_q};
        end
        cda_pkg::OP_MONTH_YEAR: begin
          wm <= rem + 4'd1;
          if (ysum_months > YMAX17) begin
            st <= cda_pkg::ST_RANGE;
          end else begin
            wy <= ysum_months[13:0];
          end
        end
        cda_pkg::OP_YEAR_ADD: begin
          if (ysum_years > YMAX17) begin
            st <= cda_pkg::ST_RANGE;
          end else begin
            wy <= ysum_years[13:0];
          end
        end
        cda_pkg::OP_CLAMP: begin
          if (wd > dim_cur) begin
            wd <= dim_cur;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cda_pkg::OP_FINISH) begin
      status <= st;
      if (st == cda_pkg::ST_OK) begin
        year_out  <= wy;
        month_out <= wm;
        day_out   <= wd;
      end else begin
        year_out  <= year;
        month_out <= month;
        day_out   <= day;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year      <= cda_pkg::RESET_YEAR;
      month     <= cda_pkg::RESET_MONTH;
      day       <= cda_pkg::RESET_DAY;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.op == cda_pkg::OP_FINISH) begin
        rsp_valid <= 1'b1;
        if (st == cda_pkg::ST_OK) begin
          year  <= wy;
          month <= wm;
          day   <= wd;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/calendar_date_arithmetic.sv @@
// Channel   Handshake              Payload
// request   req_valid, req_stall   command, amount, load_year, load_month, load_day
// response  rsp_valid, rsp_stall   year_out, month_out, day_out, status
//
// Load, next day and previous day run their own step; add years runs S_YADD, S_CLAMP;
// add months runs S_DIV, which splits the month total into years and months, S_MADD
// and S_CLAMP. Add days loops in S_DAYS, as the date advances by one day per cycle.
// A synchronous reset sets the date to 30 December 1998. A new request is taken while
// a response still waits; the following response waits for rsp_stall to drop.
module calendar_date_arithmetic #(
  parameter int unsigned YEAR_MAX = cda_pkg::YEAR_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  command,
  input  logic [15:0] amount,
  input  logic [13:0] load_year,
  input  logic [3:0]  load_month,
  input  logic [4:0]  load_day,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [1:0]  status
);

  cda_pkg::dp_cmd_t  cmd;
  cda_pkg::dp_stat_t stat;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .command   (command),
    .stat      (stat),
    .cmd       (cmd)
  );

  cda_datapath #(
    .YEAR_MAX (YEAR_MAX)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .amount     (amount),
    .load_year  (load_year),
    .load_month (load_month),
    .load_day   (load_day),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .status     (status)
  );

endmodule
